// File: rtl/pemb64_pkg.sv
`default_nettype none
package pemb64_pkg;

  // One word of the PEM text stream.
  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_marker;
  } in_word_t;

  // One decoded result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic [2:0] kind;
    logic       last_of_run;
  } out_word_t;

  // Result kinds.
  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_HDR_ERR  = 3'd1;
  localparam logic [2:0] KIND_BAD_CHAR = 3'd2;
  localparam logic [2:0] KIND_WARN     = 3'd3;
  localparam logic [2:0] KIND_FINISHED = 3'd4;
  localparam logic [2:0] KIND_TRUNC    = 3'd5;

  // Parser phases.
  localparam logic [2:0] PH_PREFIX  = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_BODY    = 3'd2;
  localparam logic [2:0] PH_TRAILER = 3'd3;
  localparam logic [2:0] PH_DRAIN   = 3'd4;
  localparam logic [2:0] PH_DONE    = 3'd5;
  localparam logic [2:0] PH_ERROR   = 3'd6;

  // Character classes beyond the 64 sextet values.
  localparam logic [6:0] CLS_PAD     = 7'd64;
  localparam logic [6:0] CLS_NEWLINE = 7'd65;
  localparam logic [6:0] CLS_DASH    = 7'd66;
  localparam logic [6:0] CLS_BAD     = 7'd67;

  localparam logic [7:0] CHAR_NL   = 8'h0A;
  localparam logic [7:0] CHAR_DASH = 8'h2D;

  localparam int unsigned BEGIN_LEN = 11;
  localparam int unsigned END_LEN   = 8;

  // Characters of the prefix "-----BEGIN ".
  function automatic logic [7:0] begin_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: ch = 8'h2D;
      4'd5:    ch = 8'h42;
      4'd6:    ch = 8'h45;
      4'd7:    ch = 8'h47;
      4'd8:    ch = 8'h49;
      4'd9:    ch = 8'h4E;
      4'd10:   ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  // Characters of the trailer "----END ".
  function automatic logic [7:0] end_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0, 3'd1, 3'd2, 3'd3: ch = 8'h2D;
      3'd4:    ch = 8'h45;
      3'd5:    ch = 8'h4E;
      3'd6:    ch = 8'h44;
      default: ch = 8'h20;
    endcase
    return ch;
  endfunction

  // Maps a body character to its sextet value or to a class code.
  function automatic logic [6:0] classify(input logic [7:0] c);
    logic [6:0] cls;
    if (c >= 8'h41 && c <= 8'h5A) begin
      cls = 7'(c - 8'd65);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      cls = 7'(c - 8'd71);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      cls = 7'(c + 8'd4);
    end else if (c == 8'h2B) begin
      cls = 7'd62;
    end else if (c == 8'h2F) begin
      cls = 7'd63;
    end else if (c == 8'h3D) begin
      cls = CLS_PAD;
    end else if (c == CHAR_NL) begin
      cls = CLS_NEWLINE;
    end else if (c == CHAR_DASH) begin
      cls = CLS_DASH;
    end else begin
      cls = CLS_BAD;
    end
    return cls;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pem_base64_stream_decoder.sv
// PEM base64 stream decoder.
// The input channel takes one word per cycle while in_stall_o is low: a byte
// of PEM text, or an end marker that closes the stream. The block checks the
// "-----BEGIN " prefix and the header line, decodes the base64 body and checks
// the "-----END " trailer. The output channel gives one result word per cycle
// while out_stall_i is low: a decoded byte, or a status kind (header error, bad
// body char, trailer warning, finished, truncated body). last_of_run marks the
// final result caused by an input word. Each accepted word is parsed in the
// cycle it is accepted and its results (zero to three) go into an eight-entry
// result queue, behind any older results. Throughput is one input word per
// cycle while in_stall_o is low; a complete quartet costs four input words and
// yields three results, so the queue keeps pace with a receiver that never
// stalls. in_stall_o rises while the queue holds more than five results, so
// that there is always room for a full quartet. A stalled output holds its
// word. Reset clears the parser state and empties the queue. After an error or
// after the stream is finished, input words are taken but give no result.
`default_nettype none
module pem_base64_stream_decoder (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire pemb64_pkg::in_word_t  in_word_i,
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output pemb64_pkg::out_word_t      out_word_o
);

  // Parser state.
  logic [2:0]  phase_q, phase_d;
  logic [3:0]  match_q, match_d;
  logic [2:0]  dash_q, dash_d;
  logic [1:0]  quart_q, quart_d;
  logic [17:0] acc_q, acc_d;
  logic [1:0]  pad_q, pad_d;

  // Result queue.
  pemb64_pkg::out_word_t mem_q [8];
  logic [2:0] wptr_q, wptr_d;
  logic [2:0] rptr_q, rptr_d;
  logic [3:0] cnt_q, cnt_d;

  pemb64_pkg::out_word_t res [3];
  logic [1:0] res_n;
  logic       in_acc;
  logic       out_acc;

  logic [7:0]  c;
  logic        eos;
  logic [6:0]  cls;
  logic [5:0]  sext;
  logic [23:0] full;
  logic [1:0]  nbytes;

  assign in_stall_o  = (cnt_q > 4'd5);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != 4'd0);
  assign out_acc     = out_valid_o && !out_stall_i;
  assign out_word_o  = mem_q[rptr_q];

  assign c   = in_word_i.in_byte;
  assign eos = in_word_i.end_marker;
  assign cls = pemb64_pkg::classify(c);

  // Per-word parse step: next state and the results this word causes.
  always_comb begin
    phase_d = phase_q;
    match_d = match_q;
    dash_d  = dash_q;
    quart_d = quart_q;
    acc_d   = acc_q;
    pad_d   = pad_q;
    res_n   = 2'd0;
    sext    = cls[5:0];
    full    = '0;
    nbytes  = 2'd0;
    for (int k = 0; k < 3; k++) begin
      res[k] = '0;
    end

    case (phase_q)
      pemb64_pkg::PH_PREFIX: begin
        if (eos || match_q > 4'(pemb64_pkg::BEGIN_LEN - 1)
            || c != pemb64_pkg::begin_char(match_q)) begin
          res[0].kind = pemb64_pkg::KIND_HDR_ERR;
          res[0].last_of_run = 1'b1;
          res_n   = 2'd1;
          phase_d = pemb64_pkg::PH_ERROR;
        end else if (match_q == 4'(pemb64_pkg::BEGIN_LEN - 1)) begin
          match_d = '0;
          dash_d  = '0;
          phase_d = pemb64_pkg::PH_HEADER;
        end else begin
          match_d = match_q + 4'd1;
        end
      end
      pemb64_pkg::PH_HEADER: begin
        if (eos || (c == pemb64_pkg::CHAR_NL && dash_q != 3'd5)) begin
          res[0].kind = pemb64_pkg::KIND_HDR_ERR;
          res[0].last_of_run = 1'b1;
          res_n   = 2'd1;
          phase_d = pemb64_pkg::PH_ERROR;
        end else if (c == pemb64_pkg::CHAR_NL) begin
          quart_d = '0;
          acc_d   = '0;
          pad_d   = '0;
          phase_d = pemb64_pkg::PH_BODY;
        end else if (c == pemb64_pkg::CHAR_DASH) begin
          if (dash_q < 3'd6) begin
            dash_d = dash_q + 3'd1;
          end
        end else begin
          dash_d = '0;
        end
      end
      pemb64_pkg::PH_BODY: begin
        if (eos) begin
          res[0].kind = pemb64_pkg::KIND_TRUNC;
          res[0].last_of_run = 1'b1;
          res_n   = 2'd1;
          phase_d = pemb64_pkg::PH_ERROR;
        end else if (cls == pemb64_pkg::CLS_NEWLINE) begin
          // Line breaks inside the body are skipped.
        end else if (cls == pemb64_pkg::CLS_DASH) begin
          quart_d = '0;
          acc_d   = '0;
          pad_d   = '0;
          match_d = '0;
          phase_d = pemb64_pkg::PH_TRAILER;
        end else if (cls == pemb64_pkg::CLS_BAD) begin
          res[0].kind = pemb64_pkg::KIND_BAD_CHAR;
          res[0].last_of_run = 1'b1;
          res_n   = 2'd1;
          phase_d = pemb64_pkg::PH_ERROR;
        end else begin
          // Padding is a zero sextet that also suppresses output bytes.
          if (cls == pemb64_pkg::CLS_PAD) begin
            sext = '0;
            if (pad_q < 2'd3) begin
              pad_d = pad_q + 2'd1;
            end
          end
          if (quart_q < 2'd3) begin
            acc_d   = {acc_q[11:0], sext};
            quart_d = quart_q + 2'd1;
          end else begin
            full   = {acc_q, sext};
            nbytes = 2'd3 - pad_d;
            res[0].out_byte = full[23:16];
            res[1].out_byte = full[15:8];
            res[2].out_byte = full[7:0];
            res_n = nbytes;
            case (nbytes)
              2'd1:    res[0].last_of_run = 1'b1;
              2'd2:    res[1].last_of_run = 1'b1;
              2'd3:    res[2].last_of_run = 1'b1;
              default: res[0].last_of_run = 1'b0;
            endcase
            quart_d = '0;
            acc_d   = '0;
            pad_d   = '0;
          end
        end
      end
      pemb64_pkg::PH_TRAILER: begin
        if (eos) begin
          res[0].kind = pemb64_pkg::KIND_WARN;
          res[1].kind = pemb64_pkg::KIND_FINISHED;
          res[1].last_of_run = 1'b1;
          res_n   = 2'd2;
          phase_d = pemb64_pkg::PH_DONE;
        end else if (match_q > 4'(pemb64_pkg::END_LEN - 1)
                     || c != pemb64_pkg::end_char(match_q[2:0])) begin
          res[0].kind = pemb64_pkg::KIND_WARN;
          res[0].last_of_run = 1'b1;
          res_n   = 2'd1;
          phase_d = pemb64_pkg::PH_DRAIN;
        end else if (match_q == 4'(pemb64_pkg::END_LEN - 1)) begin
          match_d = '0;
          phase_d = pemb64_pkg::PH_DRAIN;
        end else begin
          match_d = match_q + 4'd1;
        end
      end
      pemb64_pkg::PH_DRAIN: begin
        if (eos) begin
          res[0].kind = pemb64_pkg::KIND_FINISHED;
          res[0].last_of_run = 1'b1;
          res_n   = 2'd1;
          phase_d = pemb64_pkg::PH_DONE;
        end
      end
      default: begin
        // Done, error and unused codes ignore every word.
      end
    endcase
  end

  // Queue pointer and fill count update.
  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (in_acc) begin
      wptr_d = wptr_q + 3'(res_n);
      cnt_d  = cnt_q + 4'(res_n);
    end
    if (out_acc) begin
      rptr_d = rptr_q + 3'd1;
      cnt_d  = cnt_d - 4'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= pemb64_pkg::PH_PREFIX;
      match_q <= '0;
      dash_q  <= '0;
      quart_q <= '0;
      acc_q   <= '0;
      pad_q   <= '0;
      wptr_q  <= '0;
      rptr_q  <= '0;
      cnt_q   <= '0;
    end else begin
      if (in_acc) begin
        phase_q <= phase_d;
        match_q <= match_d;
        dash_q  <= dash_d;
        quart_q <= quart_d;
        acc_q   <= acc_d;
        pad_q   <= pad_d;
      end
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Result queue storage: up to three writes at consecutive slots.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int k = 0; k < 3; k++) begin
        if (2'(k) < res_n) begin
          mem_q[wptr_q + 3'(k)] <= res[k];
        end
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/pemb64_checker.sv
`default_nettype none
module pemb64_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        out_valid_o,
  input wire                        out_stall_i,
  input wire pemb64_pkg::out_word_t out_word_o
);

  logic terminal;

  // Error and finished words close the stream.
  assign terminal = out_word_o.kind == pemb64_pkg::KIND_HDR_ERR
                 || out_word_o.kind == pemb64_pkg::KIND_BAD_CHAR
                 || out_word_o.kind == pemb64_pkg::KIND_TRUNC
                 || out_word_o.kind == pemb64_pkg::KIND_FINISHED;

  // A stalled result word stays on the output unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled output word changed");

  // A closing word is always the final result of its input word.
  a_terminal_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && terminal |-> out_word_o.last_of_run)
    else $error("closing word without last_of_run");

  // Nothing follows a closing word until reset.
  a_nothing_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && terminal |=> !out_valid_o)
    else $error("result after a closing word");

  // Status words carry a zero byte.
  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.kind != pemb64_pkg::KIND_DATA |-> out_word_o.out_byte == 8'h00)
    else $error("status word with nonzero byte");

endmodule

bind pem_base64_stream_decoder pemb64_checker u_pemb64_checker (.*);
`default_nettype wire
